// File: design/tcac_pkg.sv
package tcac_pkg;

  localparam int COUNT_WIDTH_DEF          = 32;
  localparam int MIN_ALARM_COMPARE_DEF    = 2;
  localparam int MIN_PERIODIC_COMPARE_DEF = 2;
  localparam int CHANNEL_COUNT            = 2;

  localparam int CFG_ADDR_WIDTH = 3;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_SET     = 3'd1,
    OP_CANCEL  = 3'd2,
    OP_READ    = 3'd3,
    OP_RESTART = 3'd4
  } opcode_t;

  typedef enum logic {
    REG_GUARD  = 1'b0,
    REG_ENABLE = 1'b1
  } reg_index_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_LATE = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        channel;
    logic [31:0] alarm_ticks;
    logic        absolute;
    logic        expire_when_late;
  } item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [31:0]              count_now;
    logic [CHANNEL_COUNT-1:0] fired_mask;
    logic                     rollover;
  } result_t;

endpackage

// File: design/two_channel_alarm_counter_top.sv
// Throughput: one word per cycle unless the result side stalls (out_ready low).
// The counter and compare update is one registered pass into the result register.
// The input register and the result register let a new word enter while a result waits.
// Reset is synchronous and active low: the count, the armed flags and both valid flags clear,
// the late window resets to 0 and count_enable to 1; compare values are unknown until armed.
module two_channel_alarm_counter_top #(
  parameter int COUNT_WIDTH          = tcac_pkg::COUNT_WIDTH_DEF,
  parameter int MIN_ALARM_COMPARE    = tcac_pkg::MIN_ALARM_COMPARE_DEF,
  parameter int MIN_PERIODIC_COMPARE = tcac_pkg::MIN_PERIODIC_COMPARE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          in_opcode,
  input  logic                                in_channel,
  input  logic [31:0]                         in_alarm_ticks,
  input  logic                                in_absolute,
  input  logic                                in_expire_when_late,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_status,
  output logic [31:0]                         out_count_now,
  output logic [tcac_pkg::CHANNEL_COUNT-1:0]  out_fired_mask,
  output logic                                out_rollover,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tcac_pkg::CFG_ADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tcac_pkg::*;

  item_t       item_r;
  logic        item_vld_r;
  result_t     res_r, res_nxt;
  logic        out_vld_r;
  logic        advance;
  logic [31:0] guard_r;
  logic        enable_r;
  logic        cfg_wr;

  assign advance  = item_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.opcode           <= in_opcode;
      item_r.channel          <= in_channel;
      item_r.alarm_ticks      <= in_alarm_ticks;
      item_r.absolute         <= in_absolute;
      item_r.expire_when_late <= in_expire_when_late;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  tcac_core #(
    .COUNT_WIDTH          (COUNT_WIDTH),
    .MIN_ALARM_COMPARE    (MIN_ALARM_COMPARE),
    .MIN_PERIODIC_COMPARE (MIN_PERIODIC_COMPARE)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .item         (item_r),
    .late_window  (guard_r),
    .count_enable (enable_r),
    .result       (res_nxt)
  );

  assign out_valid      = out_vld_r;
  assign out_status     = res_r.status;
  assign out_count_now  = res_r.count_now;
  assign out_fired_mask = res_r.fired_mask;
  assign out_rollover   = res_r.rollover;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      guard_r  <= '0;
      enable_r <= 1'b1;
    end else if (cfg_wr) begin
      unique case (reg_index_t'(paddr[2]))
        REG_GUARD:  guard_r  <= pwdata;
        REG_ENABLE: enable_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_GUARD:  prdata = guard_r;
      REG_ENABLE: prdata = {31'd0, enable_r};
      default:    prdata = '0;
    endcase
  end

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_vld_r)
    else $error("input stalled with an empty input register");

  a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("processed word did not produce a result");

  a_rollover_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rollover |-> (out_count_now == '0) && (out_status == ST_OK))
    else $error("rollover reported with a nonzero count");

  a_busy_fires_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_BUSY) |-> (out_fired_mask == '0))
    else $error("busy set reported a fired channel");

endmodule

// File: design/tcac_core.sv
module tcac_core #(
  parameter int COUNT_WIDTH          = tcac_pkg::COUNT_WIDTH_DEF,
  parameter int MIN_ALARM_COMPARE    = tcac_pkg::MIN_ALARM_COMPARE_DEF,
  parameter int MIN_PERIODIC_COMPARE = tcac_pkg::MIN_PERIODIC_COMPARE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  tcac_pkg::item_t   item,
  input  logic [31:0]       late_window,
  input  logic              count_enable,
  output tcac_pkg::result_t result
);
  import tcac_pkg::*;

  localparam int CW   = COUNT_WIDTH;
  localparam int CMPW = (CW > 32) ? CW : 32;
  localparam logic [CW-1:0] LIM0   = CW'(MIN_ALARM_COMPARE);
  localparam logic [CW-1:0] LIM0P1 = CW'(MIN_ALARM_COMPARE + 1);
  localparam logic [CW-1:0] LIM1   = CW'(MIN_PERIODIC_COMPARE);
  localparam logic [CW-1:0] LIM1P1 = CW'(MIN_PERIODIC_COMPARE + 1);

  logic [CW-1:0]            count_r, count_nxt;
  logic [CW-1:0]            compare_r   [CHANNEL_COUNT];
  logic [CW-1:0]            compare_nxt [CHANNEL_COUNT];
  logic [CHANNEL_COUNT-1:0] armed_r, armed_nxt;

  logic [CW-1:0]            ticks, inc, late_diff, target, clamped, lim, lim_p1;
  logic                     late, immediate, roll;
  logic [1:0]               status;
  logic [CHANNEL_COUNT-1:0] fired;

  assign ticks     = CW'(item.alarm_ticks);
  assign inc       = count_r + CW'(1);
  assign late_diff = count_r - ticks;
  assign late      = CMPW'(late_diff) <= CMPW'(late_window);
  assign target    = item.absolute ? ticks : (count_r + ticks);
  assign lim       = item.channel ? LIM1 : LIM0;
  assign lim_p1    = item.channel ? LIM1P1 : LIM0P1;
  assign clamped   = (target <= lim) ? lim_p1 : target;

  // A relative target of zero or one tick from now is already due.
  assign immediate = (ticks == '0) || (ticks == CW'(1));

  always_comb begin
    count_nxt   = count_r;
    armed_nxt   = armed_r;
    compare_nxt = compare_r;
    status      = ST_OK;
    fired       = '0;
    roll        = 1'b0;
    unique case (item.opcode)
      OP_TICK: begin
        if (count_enable) begin
          count_nxt = inc;
          roll      = (inc == '0);
          for (int c = 0; c < CHANNEL_COUNT; c++) begin
            if (armed_r[c] && (compare_r[c] == inc)) begin
              fired[c]     = 1'b1;
              armed_nxt[c] = 1'b0;
            end
          end
        end
      end
      OP_SET: begin
        if (armed_r[item.channel]) begin
          status = ST_BUSY;
        end else if (item.absolute && late) begin
          status              = ST_LATE;
          fired[item.channel] = item.expire_when_late;
        end else if (!item.absolute && immediate) begin
          fired[item.channel] = 1'b1;
        end else begin
          compare_nxt[item.channel] = clamped;
          armed_nxt[item.channel]   = 1'b1;
        end
      end
      OP_CANCEL: begin
        armed_nxt[item.channel] = 1'b0;
      end
      OP_RESTART: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign result.status     = status;
  assign result.count_now  = 32'(count_nxt);
  assign result.fired_mask = fired;
  assign result.rollover   = roll;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      armed_r <= '0;
    end else if (advance) begin
      count_r <= count_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      compare_r <= compare_nxt;
    end
  end

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tcac_pkg::*;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_WORDS = 92;
  localparam logic [31:0] HALF_RANGE = 32'h7FFF_FFFF;

  class alarm_scoreboard;
    logic [31:0] guard_ticks;
    logic        count_on;
    logic [31:0] count_value;
    logic [31:0] compare_at [CHANNEL_COUNT];
    logic        armed [CHANNEL_COUNT];
    result_t     pending_results [$];
    int errors;
    int n_words;
    int n_results;
    int n_fired;
    int n_late;
    int n_busy;

    function new();
      guard_ticks = '0;
      count_on    = 1'b1;
      count_value = '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        compare_at[c] = '0;
        armed[c]      = 1'b0;
      end
      errors    = 0;
      n_words   = 0;
      n_results = 0;
      n_fired   = 0;
      n_late    = 0;
      n_busy    = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [31:0] val);
      if (idx == REG_GUARD) begin
        guard_ticks = val;
      end else begin
        count_on = val[0];
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function logic [1:0] program_alarm(item_t w, inout logic [1:0] fired);
      logic [31:0] tgt;
      logic [31:0] d;
      logic [31:0] lim;
      logic [31:0] maxrel;
      logic        capable;
      if (armed[w.channel]) return ST_BUSY;
      if (w.absolute) begin
        tgt = w.alarm_ticks;
        d   = count_value - tgt;
        if (d <= guard_ticks) begin
          if (w.expire_when_late) fired[w.channel] = 1'b1;
          return ST_LATE;
        end
      end else begin
        capable = (w.alarm_ticks < HALF_RANGE);
        maxrel  = capable ? HALF_RANGE : 32'hFFFF_FFFF;
        tgt     = count_value + w.alarm_ticks;
        d       = tgt - 32'd1 - count_value;
        if (d == '0 || d > maxrel) begin
          if (capable) fired[w.channel] = 1'b1;
          return ST_OK;
        end
      end
      lim = (w.channel == 1'b0) ? MIN_ALARM_COMPARE_DEF : MIN_PERIODIC_COMPARE_DEF;
      if (tgt <= lim) tgt = lim + 32'd1;
      compare_at[w.channel] = tgt;
      armed[w.channel]      = 1'b1;
      return ST_OK;
    endfunction

    function void accept_word(item_t w);
      result_t     r;
      logic [1:0]  fired;
      r     = '0;
      fired = '0;
      case (w.opcode)
        OP_TICK: begin
          if (count_on) begin
            count_value = count_value + 32'd1;
            r.rollover  = (count_value == '0);
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
              if (armed[c] && compare_at[c] == count_value) begin
                fired[c] = 1'b1;
                armed[c] = 1'b0;
              end
            end
          end
        end
        OP_SET: begin
          r.status = program_alarm(w, fired);
        end
        OP_CANCEL: begin
          armed[w.channel] = 1'b0;
        end
        OP_RESTART: begin
          count_value = '0;
        end
        default: begin
        end
      endcase
      r.fired_mask = fired;
      r.count_now  = count_value;
      pending_results.push_back(r);
      n_words++;
      n_fired += fired[0] + fired[1];
      if (r.status == ST_LATE) n_late++;
      if (r.status == ST_BUSY) n_busy++;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= 100) begin
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
    endtask

    task check_word(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        report("result with nothing outstanding", got.count_now, '0);
        return;
      end
      want = pending_results.pop_front();
      n_results++;
      if (got.status !== want.status) report("status", got.status, want.status);
      if (got.count_now !== want.count_now) report("count_now", got.count_now, want.count_now);
      if (got.fired_mask !== want.fired_mask) begin
        report("fired_mask", got.fired_mask, want.fired_mask);
      end
      if (got.rollover !== want.rollover) report("rollover", got.rollover, want.rollover);
    endtask
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic [2:0]                in_opcode;
  logic                      in_channel;
  logic [31:0]               in_alarm_ticks;
  logic                      in_absolute;
  logic                      in_expire_when_late;
  logic                      out_valid;
  logic                      out_ready;
  logic [1:0]                out_status;
  logic [31:0]               out_count_now;
  logic [CHANNEL_COUNT-1:0]  out_fired_mask;
  logic                      out_rollover;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_WIDTH-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  alarm_scoreboard sb;
  int  idle_pct;
  bit  hold_req;
  int  cycles;

  two_channel_alarm_counter_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_opcode           (in_opcode),
    .in_channel          (in_channel),
    .in_alarm_ticks      (in_alarm_ticks),
    .in_absolute         (in_absolute),
    .in_expire_when_late (in_expire_when_late),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_count_now       (out_count_now),
    .out_fired_mask      (out_fired_mask),
    .out_rollover        (out_rollover),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles without finishing.", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_word({out_status, out_count_now, out_fired_mask, out_rollover});
    end
  end

  // The result side stalls at random, and once holds off long enough to back up the input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = ($urandom_range(99) >= idle_pct);
    end
  end

  function automatic item_t word_of(logic [2:0] op, logic ch, logic [31:0] ticks,
                                    logic abs_t, logic late);
    item_t w;
    w.opcode           = op;
    w.channel          = ch;
    w.alarm_ticks      = ticks;
    w.absolute         = abs_t;
    w.expire_when_late = late;
    return w;
  endfunction

  function automatic item_t rand_word();
    item_t       w;
    int unsigned pick;
    w.channel          = 1'($urandom_range(1));
    w.alarm_ticks      = $urandom;
    w.absolute         = 1'($urandom_range(1));
    w.expire_when_late = 1'($urandom_range(1));
    pick = $urandom_range(99);
    if (pick < 45) begin
      w.opcode = OP_TICK;
    end else if (pick < 77) begin
      w.opcode = OP_SET;
      pick = $urandom_range(99);
      if (pick < 50) begin
        w.absolute    = 1'b0;
        w.alarm_ticks = $urandom_range(40);
      end else if (pick < 65) begin
        w.absolute = 1'b0;
      end else if (pick < 90) begin
        w.absolute    = 1'b1;
        w.alarm_ticks = sb.count_value + $urandom_range(50) - 32'd10;
      end else begin
        w.absolute = 1'b1;
      end
    end else if (pick < 86) begin
      w.opcode = OP_CANCEL;
    end else if (pick < 91) begin
      w.opcode = OP_READ;
    end else if (pick < 96) begin
      w.opcode = OP_RESTART;
    end else begin
      w.opcode = 3'($urandom_range(7, 5));
    end
    return w;
  endfunction

  task automatic send_word(input item_t w);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid            = 1'b1;
    in_opcode           = w.opcode;
    in_channel          = w.channel;
    in_alarm_ticks      = w.alarm_ticks;
    in_absolute         = w.absolute;
    in_expire_when_late = w.expire_when_late;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_word(w);
    @(negedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic quiesce();
    int waited;
    waited   = 0;
    in_valid = 1'b0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    item_t       directed [$];
    logic [31:0] guard_v;
    logic        enable_v;
    sb                  = new();
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_opcode           = OP_READ;
    in_channel          = 1'b0;
    in_alarm_ticks      = '0;
    in_absolute         = 1'b0;
    in_expire_when_late = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    idle_pct            = 22;
    hold_req            = 1'b0;
    cycles              = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    cfg_write(REG_GUARD, 32'd0);
    cfg_write(REG_ENABLE, 32'd1);

    directed.push_back(word_of(OP_READ, 1'b0, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_TICK, 1'b0, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b0, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b1, 32'd1, 1'b0, 1'b0));
    directed.push_back(word_of(OP_RESTART, 1'b0, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b0, 32'd2, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b0, 32'd9, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b1, 32'd0, 1'b1, 1'b1));
    directed.push_back(word_of(OP_SET, 1'b1, 32'd0, 1'b1, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b1, 32'hFFFF_FFFF, 1'b0, 1'b1));
    directed.push_back(word_of(OP_CANCEL, 1'b1, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_CANCEL, 1'b1, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b1, HALF_RANGE, 1'b0, 1'b0));
    directed.push_back(word_of(OP_CANCEL, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    repeat (3) directed.push_back(word_of(OP_TICK, 1'b0, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b1, 32'd5, 1'b1, 1'b0));
    directed.push_back(word_of(OP_SET, 1'b0, 32'd1, 1'b1, 1'b0));
    directed.push_back(word_of(OP_RESTART, 1'b0, 32'd0, 1'b0, 1'b0));
    repeat (5) directed.push_back(word_of(OP_TICK, 1'b0, 32'd0, 1'b0, 1'b0));
    directed.push_back(word_of(3'd5, 1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1));
    directed.push_back(word_of(3'd7, 1'b0, 32'd0, 1'b0, 1'b0));
    foreach (directed[i]) send_word(directed[i]);

    for (int p = 0; p < 6; p++) begin
      quiesce();
      case (p)
        0: begin guard_v = 32'hFFFF_FFFF; enable_v = 1'b1; end
        1: begin guard_v = 32'd0; enable_v = 1'b1; end
        2: begin guard_v = $urandom_range(64, 1); enable_v = 1'b1; end
        3: begin guard_v = 32'd3; enable_v = 1'b0; end
        4: begin guard_v = $urandom; enable_v = 1'b1; end
        default: begin guard_v = 32'd0; enable_v = 1'b1; end
      endcase
      cfg_write(REG_GUARD, guard_v);
      cfg_write(REG_ENABLE, {31'd0, enable_v});
      idle_pct = (p == 1) ? 0 : 22;
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 4 && i == 40) quiesce();
        send_word(rand_word());
      end
    end

    quiesce();
    if (sb.pending() != 0) begin
      sb.report("results never delivered", sb.pending(), 32'd0);
    end
    $display("Ran %0d words through six register settings and got %0d results back.",
             sb.n_words, sb.n_results);
    $display("Saw %0d alarm firings, %0d late absolute targets and %0d busy sets; %0d errors.",
             sb.n_fired, sb.n_late, sb.n_busy, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
design/tcac_pkg.sv
design/tcac_core.sv
design/two_channel_alarm_counter_top.sv
tb/tb_top.sv
